@@ design/piecewise_linear_interpolator_macros.svh @@
// assertion macros of the interpolator
// no dependencies; included by the top level
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PIL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define PIL_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ design/pil_pkg.sv @@
// types and constants of the piecewise linear interpolator
// no dependencies
package pil_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int INDEX_WIDTH = 4;
   localparam int COUNT_WIDTH = 5;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(2);
   localparam int COUNT_MIN = 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WAIT_FIRST,
      ST_FIRST,
      ST_WAIT_NEXT,
      ST_SCAN,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic write_point;
      logic start_eval;
      logic take_first;
      logic take_left;
      logic take_last;
      logic take_right;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic finish;
      logic push;
   } ctl_cmd_type;

   typedef struct packed {
      logic below_time;
      logic at_end;
      logic mul_last;
      logic div_last;
   } dp_status_type;

endpackage

@@ design/pil_if.sv @@
// channel interfaces of the interpolator: request, response, register write
// depends on pil_pkg
interface pil_req_if import pil_pkg::*; #(parameter int DATA_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [INDEX_WIDTH-1:0]        point_index;
   logic signed [DATA_WIDTH-1:0]  point_time;
   logic signed [DATA_WIDTH-1:0]  point_value;
   logic signed [DATA_WIDTH-1:0]  sample_time;

   modport source (output valid, command, point_index, point_time, point_value,
                   sample_time, input ready);
   modport sink (input valid, command, point_index, point_time, point_value,
                 sample_time, output ready);
endinterface

interface pil_rsp_if import pil_pkg::*; #(parameter int DATA_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  result_value;
   logic [COUNT_WIDTH-1:0]        segment;

   modport source (output valid, result_value, segment, input ready);
   modport sink (input valid, result_value, segment, output ready);
endinterface

interface pil_csr_if import pil_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ design/pil_datapath.sv @@
// interpolator datapath: breakpoint memory, segment search registers,
// shift-add multiplier, restoring divider and result registers; uses pil_pkg
module pil_datapath import pil_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_cmd_type                   cmd,
   output dp_status_type                 status,
   input  logic [INDEX_WIDTH-1:0]        point_index,
   input  logic signed [DATA_WIDTH-1:0]  point_time,
   input  logic signed [DATA_WIDTH-1:0]  point_value,
   input  logic signed [DATA_WIDTH-1:0]  sample_time,
   input  logic                          csr_write,
   input  logic [COUNT_WIDTH-1:0]        csr_data,
   output logic signed [DATA_WIDTH-1:0]  result_value,
   output logic [COUNT_WIDTH-1:0]        segment
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW + 1;
   localparam int CW = $clog2(DW + 2);

   // breakpoint memory
   logic signed [DW-1:0] times_mem [MAX_POINTS];
   logic signed [DW-1:0] values_mem [MAX_POINTS];
   logic signed [DW-1:0] rd_t_ff, rd_v_ff;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] k_ff, k_in;
   logic signed [DW-1:0]   t_ff, lx_ff, ly_ff;
   logic [DW:0]            mag_ff;
   logic                   neg_ff;
   logic [DW-1:0]          dt_ff, d_ff;
   logic [PW-1:0]          prod_ff;
   logic [DW-1:0]          rem_ff;
   logic [DW:0]            quo_ff;
   logic [CW-1:0]          cnt_ff;
   logic signed [DW-1:0]   res_ff, out_res_ff;
   logic [COUNT_WIDTH-1:0] seg_ff, out_seg_ff;

   logic signed [DW:0]     dy, dt_full, d_full, sum;
   logic [DW:0]            trial;
   logic                   ge;
   logic                   in_range;

   // register write with clamping
   always_comb begin
      count_in = count_ff;
      if (csr_write) begin
         if (int'(csr_data) < COUNT_MIN) begin
            count_in = COUNT_WIDTH'(COUNT_MIN);
         end else if (int'(csr_data) > MAX_POINTS) begin
            count_in = COUNT_WIDTH'(MAX_POINTS);
         end else begin
            count_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // memory write on load items, registered read at the search index
   assign in_range = int'(point_index) < MAX_POINTS;

   always_ff @(posedge clock) begin
      if (cmd.write_point && in_range) begin
         times_mem[AW'(point_index)]  <= point_time;
         values_mem[AW'(point_index)] <= point_value;
      end
      rd_t_ff <= times_mem[AW'(k_ff)];
      rd_v_ff <= values_mem[AW'(k_ff)];
   end

   // search index
   always_comb begin
      k_in = k_ff;
      if (cmd.start_eval) begin
         k_in = '0;
      end else if (cmd.take_left) begin
         k_in = k_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   // segment operands
   assign dy      = {rd_v_ff[DW-1], rd_v_ff} - {ly_ff[DW-1], ly_ff};
   assign dt_full = {t_ff[DW-1], t_ff} - {lx_ff[DW-1], lx_ff};
   assign d_full  = {rd_t_ff[DW-1], rd_t_ff} - {lx_ff[DW-1], lx_ff};

   // divider step
   assign trial = {rem_ff, quo_ff[DW]};
   assign ge    = trial >= {1'b0, d_ff};

   // final sum lies between the two end values
   assign sum = neg_ff ? ({ly_ff[DW-1], ly_ff} - $signed(quo_ff))
                       : ({ly_ff[DW-1], ly_ff} + $signed(quo_ff));

   always_ff @(posedge clock) begin
      if (cmd.start_eval) begin
         t_ff <= sample_time;
      end
      if (cmd.take_left) begin
         lx_ff <= rd_t_ff;
         ly_ff <= rd_v_ff;
      end
      if (cmd.take_first) begin
         res_ff <= rd_v_ff;
         seg_ff <= '0;
      end
      if (cmd.take_last) begin
         res_ff <= ly_ff;
         seg_ff <= k_ff;
      end
      if (cmd.take_right) begin
         neg_ff  <= dy[DW];
         mag_ff  <= dy[DW] ? DW'(0) - dy : dy;
         dt_ff   <= dt_full[DW-1:0];
         d_ff    <= d_full[DW-1:0];
         prod_ff <= '0;
         cnt_ff  <= '0;
         seg_ff  <= k_ff;
      end
      // shift-add multiply, one bit of the time offset per cycle
      if (cmd.mul_step) begin
         prod_ff <= {prod_ff[PW-2:0], 1'b0} + (dt_ff[DW-1] ? PW'(mag_ff) : PW'(0));
         dt_ff   <= {dt_ff[DW-2:0], 1'b0};
         cnt_ff  <= cnt_ff + CW'(1);
      end
      if (cmd.div_start) begin
         rem_ff <= prod_ff[PW-1:DW+1];
         quo_ff <= prod_ff[DW:0];
         cnt_ff <= '0;
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         rem_ff <= ge ? DW'(trial - {1'b0, d_ff}) : trial[DW-1:0];
         quo_ff <= {quo_ff[DW-1:0], ge};
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.finish) begin
         res_ff <= sum[DW-1:0];
      end
      if (cmd.push) begin
         out_res_ff <= res_ff;
         out_seg_ff <= seg_ff;
      end
   end

   assign status.below_time = t_ff < rd_t_ff;
   assign status.at_end     = k_ff == count_ff;
   assign status.mul_last   = cnt_ff == CW'(DW - 1);
   assign status.div_last   = cnt_ff == CW'(DW);

   assign result_value = out_res_ff;
   assign segment      = out_seg_ff;

endmodule

@@ design/pil_controller.sv @@
// interpolator controller: sequences search, multiply, divide and output
// depends on pil_pkg
module pil_controller import pil_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_LOAD) begin
                  cmd.write_point = 1'b1;
               end else begin
                  cmd.start_eval = 1'b1;
                  state_in       = ST_WAIT_FIRST;
               end
            end
         end
         ST_WAIT_FIRST: state_in = ST_FIRST;
         ST_FIRST: begin
            if (status.below_time) begin
               cmd.take_first = 1'b1;
               state_in       = ST_PUSH;
            end else begin
               cmd.take_left = 1'b1;
               state_in      = ST_WAIT_NEXT;
            end
         end
         ST_WAIT_NEXT: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.at_end) begin
               cmd.take_last = 1'b1;
               state_in      = ST_PUSH;
            end else if (status.below_time) begin
               cmd.take_right = 1'b1;
               state_in       = ST_MUL;
            end else begin
               cmd.take_left = 1'b1;
               state_in      = ST_WAIT_NEXT;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.push     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ design/piecewise_linear_interpolator.sv @@
// load item: accepted while idle, no result; evaluate item: breakpoints read one at a time
// (one memory port), k = segment reached; result either clamped or interpolated, the
// latter with DATA_WIDTH multiply and DATA_WIDTH+1 divide steps; one evaluate item in
// flight, next one accepted in the cycle after the result register loads;
// register writes apply next cycle
// synchronous active-high reset: idle, no result pending, point count 2, table kept
`include "piecewise_linear_interpolator_macros.svh"

module piecewise_linear_interpolator import pil_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input logic     clock,
   input logic     reset,
   pil_req_if.sink req_bus,
   pil_rsp_if.source rsp_bus,
   pil_csr_if.sink csr_bus
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          eval_take, load_take, seg_over;

   assign csr_bus.ready = 1'b1;

   // sequencing
   pil_controller u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .req_command (req_bus.command),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // storage and arithmetic
   pil_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .point_index  (req_bus.point_index),
      .point_time   (req_bus.point_time),
      .point_value  (req_bus.point_value),
      .sample_time  (req_bus.sample_time),
      .csr_write    (csr_bus.valid && csr_bus.ready),
      .csr_data     (csr_bus.data),
      .result_value (rsp_bus.result_value),
      .segment      (rsp_bus.segment)
   );

   // checks
   assign eval_take = req_bus.valid && req_bus.ready && (req_bus.command == CMD_EVAL);
   assign load_take = req_bus.valid && req_bus.ready && (req_bus.command == CMD_LOAD);
   assign seg_over  = rsp_bus.valid && (int'(rsp_bus.segment) > MAX_POINTS);

   `PIL_ASSERT(a_eval_busy, clock, reset, eval_take |=> !req_bus.ready, "evaluate item not blocking")
   `PIL_ASSERT(a_load_fast, clock, reset, load_take |=> req_bus.ready, "load item stalled requests")
   `PIL_NEVER(a_seg_range, clock, reset, seg_over, "segment beyond table size")

endmodule
